// ===== design/dense_code_word_index_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dense-code word index decoder
// Overlapping and non-overlapping implication checks.
// ----------------------------------------------------------------------------
`ifndef DENSE_CODE_WORD_INDEX_DECODER_MACROS_SVH
`define DENSE_CODE_WORD_INDEX_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DCWI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder check failed");

// next-cycle implication
`define DCWI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder check failed");

`else

`define DCWI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DCWI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/dcwi_pkg.sv =====
// ----------------------------------------------------------------------------
// dcwi_pkg
// Constants, status codes and the level offset table of the dense-code
// word index decoder.
// ----------------------------------------------------------------------------
package dcwi_pkg;

   localparam int INDEX_BITS_DEFAULT = 20;

   localparam int DIGIT_BITS      = 4;
   localparam int POS_BITS        = 2;
   localparam int COUNT_BITS      = 3;
   localparam int STATUS_BITS     = 2;
   localparam int DICT_SIZE_BITS  = 21;
   // 9^6 - 1 fits in 20 bits
   localparam int ACC_BITS        = 20;
   localparam int OFFSET_BITS     = 19;
   // largest index is (9^6 - 1) * 7 + 6 + 465010, below 2^23
   localparam int SUM_BITS        = 23;

   localparam logic [DIGIT_BITS-1:0]     STOP_LIMIT = 4'd7;
   localparam logic [COUNT_BITS-1:0]     MAX_CONT   = 3'd6;
   localparam logic [POS_BITS-1:0]       LAST_POS   = 2'd3;
   localparam logic [DICT_SIZE_BITS-1:0] DICT_SIZE_RESET = 21'h10_0000;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   // first index of each continuation level: 7 * (9^k - 1) / 8
   function automatic logic [OFFSET_BITS-1:0] level_offset(input logic [COUNT_BITS-1:0] count);
      logic [OFFSET_BITS-1:0] offset;
      unique case (count)
         3'd0:    offset = 19'd0;
         3'd1:    offset = 19'd7;
         3'd2:    offset = 19'd70;
         3'd3:    offset = 19'd637;
         3'd4:    offset = 19'd5740;
         3'd5:    offset = 19'd51667;
         3'd6:    offset = 19'd465010;
         default: offset = 19'd0;
      endcase
      return offset;
   endfunction

endpackage

// ===== design/dense_code_word_index_decoder.sv =====
// ----------------------------------------------------------------------------
// dense_code_word_index_decoder
// Serial dense-code decoder: one message bit per transfer in, at most one
// decoded dictionary index per word out.
// ----------------------------------------------------------------------------
// The block takes one message bit per clock cycle, every cycle, as long as
// the result register is free or being read in the same cycle; a result
// appears in the result register in the cycle after the bit that causes it.
// The rate is set by the single pass through the digit logic, one
// shift-and-add of the base-9 accumulator or one index sum and range compare,
// between the decoder state and the result register. Results come on the
// separator bit of a word, on an error, and always on the end-of-message bit,
// after which the decoder starts a new message. The user must write dictionary_size
// through csr_write_enable only while the block is idle; the block does not enforce it.
`include "dense_code_word_index_decoder_macros.svh"

module dense_code_word_index_decoder #(
   parameter int INDEX_BITS = dcwi_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_write_enable,
   input  logic [dcwi_pkg::DICT_SIZE_BITS-1:0]  csr_write_data,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_code_bit,
   input  logic                                 req_end_of_message,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_word_valid,
   output logic [INDEX_BITS-1:0]                rsp_word_index,
   output logic                                 rsp_space_after,
   output logic [dcwi_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                 rsp_message_done
);

   localparam int WIDE_BITS = (INDEX_BITS > dcwi_pkg::SUM_BITS) ?
                              INDEX_BITS : dcwi_pkg::SUM_BITS;

   // decoder state
   logic [dcwi_pkg::DICT_SIZE_BITS-1:0] dict_size_ff;
   logic [dcwi_pkg::DIGIT_BITS-1:0]     digit_shift_ff, digit_shift_in;
   logic [dcwi_pkg::POS_BITS-1:0]       bit_pos_ff, bit_pos_in;
   logic [dcwi_pkg::ACC_BITS-1:0]       cont_acc_ff, cont_acc_in;
   logic [dcwi_pkg::COUNT_BITS-1:0]     cont_count_ff, cont_count_in;
   logic                                await_sep_ff, await_sep_in;
   logic [INDEX_BITS-1:0]               pending_ff, pending_in;
   logic [dcwi_pkg::STATUS_BITS-1:0]    halted_ff, halted_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                word_valid_ff, word_valid_in;
   logic [INDEX_BITS-1:0]               word_index_ff, word_index_in;
   logic                                space_after_ff, space_after_in;
   logic [dcwi_pkg::STATUS_BITS-1:0]    status_ff, status_in;
   logic                                done_ff, done_in;

   logic                                accept;
   logic                                emit;
   logic [dcwi_pkg::DIGIT_BITS-1:0]     digit;
   logic [dcwi_pkg::SUM_BITS-1:0]       acc_times7;
   logic [dcwi_pkg::SUM_BITS-1:0]       index_sum;
   logic [WIDE_BITS-1:0]                index_wide;
   logic                                out_of_range;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign digit = {digit_shift_ff[dcwi_pkg::DIGIT_BITS-2:0], req_code_bit};

   // index = acc * 7 + stopper + level offset
   assign acc_times7 = {cont_acc_ff, 3'b000} - dcwi_pkg::SUM_BITS'(cont_acc_ff);
   assign index_sum  = acc_times7 + dcwi_pkg::SUM_BITS'(digit) +
                       dcwi_pkg::SUM_BITS'(dcwi_pkg::level_offset(cont_count_ff));
   assign index_wide = WIDE_BITS'(index_sum);

   // limit is the smaller of the dictionary size and 2^INDEX_BITS
   assign out_of_range = (index_wide >= WIDE_BITS'(dict_size_ff)) ||
                         ((index_wide >> INDEX_BITS) != '0);

   always_comb begin
      digit_shift_in = digit_shift_ff;
      bit_pos_in     = bit_pos_ff;
      cont_acc_in    = cont_acc_ff;
      cont_count_in  = cont_count_ff;
      await_sep_in   = await_sep_ff;
      pending_in     = pending_ff;
      halted_in      = halted_ff;
      emit           = 1'b0;
      word_valid_in  = 1'b0;
      word_index_in  = '0;
      space_after_in = 1'b0;

      if (halted_ff == dcwi_pkg::STATUS_OK) begin
         if (await_sep_ff) begin
            emit           = 1'b1;
            word_valid_in  = 1'b1;
            word_index_in  = pending_ff;
            space_after_in = req_code_bit;
            await_sep_in   = 1'b0;
            pending_in     = '0;
         end else if (bit_pos_ff != dcwi_pkg::LAST_POS) begin
            digit_shift_in = digit;
            bit_pos_in     = bit_pos_ff + 1'b1;
         end else begin
            digit_shift_in = '0;
            bit_pos_in     = '0;
            if (digit >= dcwi_pkg::STOP_LIMIT) begin
               if (cont_count_ff >= dcwi_pkg::MAX_CONT) begin
                  halted_in = dcwi_pkg::STATUS_OVERFLOW;
                  emit      = 1'b1;
               end else begin
                  // base-9 step: acc * 9 + (digit - 7)
                  cont_acc_in   = {cont_acc_ff[dcwi_pkg::ACC_BITS-4:0], 3'b000} + cont_acc_ff +
                                  dcwi_pkg::ACC_BITS'(digit - dcwi_pkg::STOP_LIMIT);
                  cont_count_in = cont_count_ff + 1'b1;
               end
            end else begin
               cont_acc_in   = '0;
               cont_count_in = '0;
               if (out_of_range) begin
                  halted_in = dcwi_pkg::STATUS_RANGE;
                  emit      = 1'b1;
               end else if (req_end_of_message) begin
                  // message ends on the stopper: no separator bit
                  emit          = 1'b1;
                  word_valid_in = 1'b1;
                  word_index_in = index_wide[INDEX_BITS-1:0];
               end else begin
                  pending_in   = index_wide[INDEX_BITS-1:0];
                  await_sep_in = 1'b1;
               end
            end
         end
      end

      status_in = halted_in;
      done_in   = req_end_of_message;

      if (req_end_of_message) begin
         emit           = 1'b1;
         digit_shift_in = '0;
         bit_pos_in     = '0;
         cont_acc_in    = '0;
         cont_count_in  = '0;
         await_sep_in   = 1'b0;
         pending_in     = '0;
         halted_in      = dcwi_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_size_ff   <= dcwi_pkg::DICT_SIZE_RESET;
         digit_shift_ff <= '0;
         bit_pos_ff     <= '0;
         cont_acc_ff    <= '0;
         cont_count_ff  <= '0;
         await_sep_ff   <= 1'b0;
         pending_ff     <= '0;
         halted_ff      <= dcwi_pkg::STATUS_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            dict_size_ff <= csr_write_data;
         end
         if (accept) begin
            digit_shift_ff <= digit_shift_in;
            bit_pos_ff     <= bit_pos_in;
            cont_acc_ff    <= cont_acc_in;
            cont_count_ff  <= cont_count_in;
            await_sep_ff   <= await_sep_in;
            pending_ff     <= pending_in;
            halted_ff      <= halted_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         word_valid_ff  <= word_valid_in;
         word_index_ff  <= word_index_in;
         space_after_ff <= space_after_in;
         status_ff      <= status_in;
         done_ff        <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word_valid   = word_valid_ff;
   assign rsp_word_index   = word_index_ff;
   assign rsp_space_after  = space_after_ff;
   assign rsp_status       = status_ff;
   assign rsp_message_done = done_ff;

   // a decoded word never carries an error code
   `DCWI_ASSERT_IMPLIES(a_word_ok, clock, reset, rsp_valid_ff && word_valid_ff, status_ff == dcwi_pkg::STATUS_OK)

   // no word means no index and no space
   `DCWI_ASSERT_IMPLIES(a_empty_clean, clock, reset, rsp_valid_ff && !word_valid_ff, word_index_ff == '0 && !space_after_ff)

   // a halted decoder holds no pending word
   `DCWI_ASSERT_IMPLIES(a_halt_no_pending, clock, reset, halted_ff != dcwi_pkg::STATUS_OK, !await_sep_ff)

   // continuation count never passes the deepest level
   `DCWI_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, cont_count_ff <= dcwi_pkg::MAX_CONT)

   // end of message always yields a result and clears the decoder
   `DCWI_ASSERT_NEXT(a_eom_clear, clock, reset, accept && req_end_of_message, rsp_valid_ff && done_ff && bit_pos_ff == '0 && cont_count_ff == '0 && halted_ff == dcwi_pkg::STATUS_OK)

endmodule
